// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL of the normalised 3x3 filter.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define NC3_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Condition that must never be seen outside reset.
`define NC3_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("forbidden condition seen");

`endif

// ===== hdl/nc3_pkg.sv =====
// Types and constants shared by the normalised 3x3 filter modules.
// Depends on nothing.
`default_nettype none
package nc3_pkg;

    localparam int NTAPS     = 9;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR  = 2'd3;

    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam int SAMPLE_W = 8;
    localparam int DIM_W    = 11;

    // Border and frame flags of one queued output job.
    typedef struct packed {
        logic left;
        logic right;
        logic top;
        logic bottom;
        logic last;
    } t_job_flags;

    // Frame progress seen by the top level.
    typedef struct packed {
        logic in_done;
        logic out_done;
    } t_front_stat;

endpackage
`default_nettype wire

// ===== hdl/normalized_conv_3x3_filter_unit.sv =====
// Top level of the normalised 3x3 convolution filter: configuration
// registers and the wiring of front, job queue, line store and back.
// Depends on nc3_pkg, nc3_ram, nc3_job_fifo, nc3_front, nc3_back, assert_macros.svh.
//
//  Channel   Direction  Ports                         Contents
//  input     in         s_axis_t{valid,ready,data,user} sample, drain/push kind
//  output    out        m_axis_t{valid,ready,data,user,last} filtered value
//  config    in         i_cfg_{we,index,data}         register writes
//
// An input transaction is taken whenever the job queue has room, except as said below.
// Each output job passes the back in order: taken from the queue, nine neighbour
// reads issued to the single read port, the last product collected, then the
// one-bit-a-cycle divider over 8+WEIGHT_BITS+4 = 16 bits at the defaults (left
// at once when the weights sum to zero) and the output register loaded.
// The two-entry job queue lets the front accept while the back works; it
// stalls only when the queue is full, or when a new frame would start before
// the back has finished the previous one. Reset is synchronous, active low.
`default_nettype none
`include "assert_macros.svh"
module normalized_conv_3x3_filter_unit
    import nc3_pkg::*;
#(
    parameter int MAX_WIDTH   = 1024,
    parameter int MAX_HEIGHT  = 1024,
    parameter int WEIGHT_BITS = 4
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]     i_cfg_index,
    input  wire  [((NTAPS*WEIGHT_BITS > DIM_W) ? NTAPS*WEIGHT_BITS : DIM_W)-1:0] i_cfg_data,
    input  wire                      s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire  [SAMPLE_W-1:0]      s_axis_tdata,   // [7:0] sample
    input  wire                      s_axis_tuser,   // [0] operation (push / drain)
    output logic                     m_axis_tvalid,
    input  wire                      m_axis_tready,
    output logic [SAMPLE_W-1:0]      m_axis_tdata,   // [7:0] filtered_value
    output logic                     m_axis_tuser,   // [0] zero_weight_error
    output logic                     m_axis_tlast
);
    localparam int KW    = NTAPS*WEIGHT_BITS;
    localparam int WW    = $clog2(MAX_WIDTH+1);
    localparam int HW    = $clog2(MAX_HEIGHT+1);
    localparam int RSW   = $clog2(3*MAX_WIDTH+1);
    localparam int DEPTH = (2*MAX_WIDTH+3)*3;
    localparam int AW    = $clog2(DEPTH);
    localparam int JW    = AW + $bits(t_job_flags);

    // Box kernel: every weight one.
    function automatic logic [KW-1:0] box_kernel();
        logic [KW-1:0] v;
        v = '0;
        for (int i = 0; i < NTAPS; i++) begin
            v[i*WEIGHT_BITS] = 1'b1;
        end
        return v;
    endfunction

    logic [KW-1:0]    r_kernel;
    logic [DIM_W-1:0] r_width, r_height;
    logic             r_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel <= box_kernel();
            r_width  <= DIM_W'(1024);
            r_height <= DIM_W'(1024);
            r_color  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_KERNEL: r_kernel <= i_cfg_data[KW-1:0];
                CFG_WIDTH:  r_width  <= i_cfg_data[DIM_W-1:0];
                CFG_HEIGHT: r_height <= i_cfg_data[DIM_W-1:0];
                CFG_COLOR:  r_color  <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Effective dimensions: zero acts as one, oversize saturates.
    logic [WW-1:0]  w_eff;
    logic [HW-1:0]  h_eff;
    logic [RSW-1:0] rowstep;

    always_comb begin
        if (r_width == '0) begin
            w_eff = WW'(1);
        end else if (32'(r_width) > 32'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_width);
        end
        if (r_height == '0) begin
            h_eff = HW'(1);
        end else if (32'(r_height) > 32'(MAX_HEIGHT)) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(r_height);
        end
        // Distance between vertically adjacent samples of one channel.
        rowstep = r_color ? (RSW'(w_eff) + (RSW'(w_eff) << 1)) : RSW'(w_eff);
    end

    logic          push, pop, fifo_full, fifo_empty, back_st_idle, back_idle;
    logic [AW-1:0] job_addr, q_addr, waddr, raddr;
    t_job_flags    job_flags, q_flags;
    logic          we;
    logic [SAMPLE_W-1:0] wdata, rdata;
    t_front_stat   fstat;

    assign back_idle = fifo_empty && back_st_idle;

    nc3_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_op(s_axis_tuser), .i_sample(s_axis_tdata),
        .i_w_eff(w_eff), .i_h_eff(h_eff), .i_color(r_color),
        .i_back_idle(back_idle), .i_fifo_full(fifo_full),
        .o_push(push), .o_job_addr(job_addr), .o_job_flags(job_flags),
        .o_we(we), .o_waddr(waddr), .o_wdata(wdata), .o_stat(fstat)
    );

    nc3_job_fifo #(.WIDTH(JW)) u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .i_data({job_addr, job_flags}),
        .i_pop(pop), .o_data({q_addr, q_flags}),
        .o_full(fifo_full), .o_empty(fifo_empty)
    );

    nc3_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_line_store (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    nc3_back #(.MAX_WIDTH(MAX_WIDTH), .WEIGHT_BITS(WEIGHT_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_fifo_empty(fifo_empty), .o_pop(pop),
        .i_job_addr(q_addr), .i_job_flags(q_flags),
        .i_kernel(r_kernel), .i_rowstep(rowstep), .i_color(r_color),
        .o_raddr(raddr), .i_rdata(rdata),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_value(m_axis_tdata), .o_zero_err(m_axis_tuser), .o_last(m_axis_tlast),
        .o_idle(back_st_idle)
    );

    // The job queue is never written while full.
    `NC3_NEVER(a_fifo_no_overflow, i_clk, i_rst_n, push && fifo_full)
    // A zero weight sum always comes with a zero value.
    `NC3_ASSERT(a_zero_err_value, i_clk, i_rst_n, (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
    // A new frame only starts once the back has emptied.
    `NC3_ASSERT(a_restart_idle, i_clk, i_rst_n, (s_axis_tvalid && s_axis_tready && fstat.in_done && fstat.out_done) |-> back_idle)
endmodule
`default_nettype wire

// ===== hdl/nc3_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// Depends on nothing.
`default_nettype none
module nc3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 6153
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== hdl/nc3_job_fifo.sv =====
// Two-entry queue carrying output jobs from the front to the back.
// Depends on nothing.
`default_nettype none
module nc3_job_fifo #(
    parameter int WIDTH = 18
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  wire  [WIDTH-1:0] i_data,
    input  wire              i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rp];
    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
endmodule
`default_nettype wire

// ===== hdl/nc3_front.sv =====
// Front part: accepts samples and drains, writes the line store, tracks the
// input and output raster positions and queues output jobs. Uses nc3_pkg.
`default_nettype none
module nc3_front
    import nc3_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire                                        i_clk,
    input  wire                                        i_rst_n,
    input  wire                                        i_cfg_we,
    input  wire                                        i_valid,
    output logic                                       o_ready,
    input  wire                                        i_op,
    input  wire  [SAMPLE_W-1:0]                        i_sample,
    input  wire  [$clog2(MAX_WIDTH+1)-1:0]             i_w_eff,
    input  wire  [$clog2(MAX_HEIGHT+1)-1:0]            i_h_eff,
    input  wire                                        i_color,
    input  wire                                        i_back_idle,
    input  wire                                        i_fifo_full,
    output logic                                       o_push,
    output logic [$clog2((2*MAX_WIDTH+3)*3)-1:0]       o_job_addr,
    output t_job_flags                                 o_job_flags,
    output logic                                       o_we,
    output logic [$clog2((2*MAX_WIDTH+3)*3)-1:0]       o_waddr,
    output logic [SAMPLE_W-1:0]                        o_wdata,
    output t_front_stat                                o_stat
);
    localparam int WW    = $clog2(MAX_WIDTH+1);
    localparam int HW    = $clog2(MAX_HEIGHT+1);
    localparam int LW    = $clog2(3*MAX_WIDTH+5);
    localparam int DEPTH = (2*MAX_WIDTH+3)*3;
    localparam int AW    = $clog2(DEPTH);

    logic [AW-1:0] r_wptr, r_optr;
    logic [1:0]    r_in_ch, r_out_ch;
    logic [WW-1:0] r_in_c, r_out_c;
    logic [HW-1:0] r_in_r, r_out_r;
    logic          r_in_done, r_out_done;
    logic [LW-1:0] r_diff;

    logic [AW-1:0] n_wptr, n_optr, wp, op;
    logic [1:0]    n_in_ch, n_out_ch, ich, och, ch_last;
    logic [WW-1:0] n_in_c, n_out_c, ic, oc, w_m1;
    logic [HW-1:0] n_in_r, n_out_r, ir, orow, h_m1;
    logic          n_in_done, n_out_done, ind, outd;
    logic [LW-1:0] n_diff, dcur, lag_w, lag;
    logic          accept, restart, do_push, emit, in_final, out_final;

    always_comb begin
        w_m1    = i_w_eff - WW'(1);
        h_m1    = i_h_eff - HW'(1);
        ch_last = i_color ? 2'd2 : 2'd0;
        lag_w   = LW'(i_w_eff) + LW'(1);
        lag     = i_color ? (lag_w + (lag_w << 1)) : lag_w;

        o_ready = !i_fifo_full && !(r_in_done && r_out_done && !i_back_idle);
        accept  = i_valid && o_ready;
        restart = accept && (i_op == OP_PUSH) && r_in_done && r_out_done;

        ich  = restart ? 2'd0 : r_in_ch;
        ic   = restart ? '0 : r_in_c;
        ir   = restart ? '0 : r_in_r;
        ind  = restart ? 1'b0 : r_in_done;
        och  = restart ? 2'd0 : r_out_ch;
        oc   = restart ? '0 : r_out_c;
        orow = restart ? '0 : r_out_r;
        outd = restart ? 1'b0 : r_out_done;
        dcur = restart ? '0 : r_diff;
        wp   = restart ? '0 : r_wptr;
        op   = restart ? '0 : r_optr;

        do_push  = accept && (i_op == OP_PUSH) && !ind;
        in_final = (ich == ch_last) && (ic == w_m1) && (ir == h_m1);
        n_in_done = ind || (do_push && in_final);

        emit = (do_push && !outd && ((dcur + LW'(1) > lag) || n_in_done))
            || (accept && (i_op == OP_DRAIN) && r_in_done && !r_out_done);
        out_final = (och == ch_last) && (oc == w_m1) && (orow == h_m1);
        n_out_done = outd || (emit && out_final);

        n_in_ch = ich;
        n_in_c  = ic;
        n_in_r  = ir;
        if (do_push) begin
            if (ich == ch_last) begin
                n_in_ch = 2'd0;
                if (ic == w_m1) begin
                    n_in_c = '0;
                    if (ir != h_m1) begin
                        n_in_r = ir + HW'(1);
                    end
                end else begin
                    n_in_c = ic + WW'(1);
                end
            end else begin
                n_in_ch = ich + 2'd1;
            end
        end

        n_out_ch = och;
        n_out_c  = oc;
        n_out_r  = orow;
        if (emit) begin
            if (och == ch_last) begin
                n_out_ch = 2'd0;
                if (oc == w_m1) begin
                    n_out_c = '0;
                    if (orow != h_m1) begin
                        n_out_r = orow + HW'(1);
                    end
                end else begin
                    n_out_c = oc + WW'(1);
                end
            end else begin
                n_out_ch = och + 2'd1;
            end
        end

        n_diff = dcur + LW'(do_push) - LW'(emit);
        n_wptr = do_push ? ((wp == AW'(DEPTH-1)) ? '0 : wp + AW'(1)) : wp;
        n_optr = emit ? ((op == AW'(DEPTH-1)) ? '0 : op + AW'(1)) : op;

        o_we    = do_push;
        o_waddr = wp;
        o_wdata = i_sample;
        o_push  = emit;
        o_job_addr = op;
        o_job_flags.left   = (oc == '0);
        o_job_flags.right  = (oc == w_m1);
        o_job_flags.top    = (orow == '0);
        o_job_flags.bottom = (orow == h_m1);
        o_job_flags.last   = out_final;
        o_stat.in_done  = r_in_done;
        o_stat.out_done = r_out_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_wptr <= '0;  r_optr <= '0;
            r_in_ch <= '0; r_in_c <= '0; r_in_r <= '0; r_in_done <= 1'b0;
            r_out_ch <= '0; r_out_c <= '0; r_out_r <= '0; r_out_done <= 1'b0;
            r_diff <= '0;
        end else begin
            r_wptr <= n_wptr;  r_optr <= n_optr;
            r_in_ch <= n_in_ch; r_in_c <= n_in_c; r_in_r <= n_in_r;
            r_in_done <= n_in_done;
            r_out_ch <= n_out_ch; r_out_c <= n_out_c; r_out_r <= n_out_r;
            r_out_done <= n_out_done;
            r_diff <= n_diff;
        end
    end
endmodule
`default_nettype wire

// ===== hdl/nc3_back.sv =====
// Back part: reads the nine neighbours of one job from the line store,
// accumulates the weighted sum, divides bit-serially and registers the result.
// Uses nc3_pkg.
`default_nettype none
module nc3_back
    import nc3_pkg::*;
#(
    parameter int MAX_WIDTH   = 1024,
    parameter int WEIGHT_BITS = 4
) (
    input  wire                                        i_clk,
    input  wire                                        i_rst_n,
    input  wire                                        i_fifo_empty,
    output logic                                       o_pop,
    input  wire  [$clog2((2*MAX_WIDTH+3)*3)-1:0]       i_job_addr,
    input  t_job_flags                                 i_job_flags,
    input  wire  [NTAPS*WEIGHT_BITS-1:0]               i_kernel,
    input  wire  [$clog2(3*MAX_WIDTH+1)-1:0]           i_rowstep,
    input  wire                                        i_color,
    output logic [$clog2((2*MAX_WIDTH+3)*3)-1:0]       o_raddr,
    input  wire  [SAMPLE_W-1:0]                        i_rdata,
    output logic                                       o_valid,
    input  wire                                        i_ready,
    output logic [SAMPLE_W-1:0]                        o_value,
    output logic                                       o_zero_err,
    output logic                                       o_last,
    output logic                                       o_idle
);
    localparam int DEPTH = (2*MAX_WIDTH+3)*3;
    localparam int AW    = $clog2(DEPTH);
    localparam int TW    = AW + 2;
    localparam int SW    = WEIGHT_BITS + 4;
    localparam int ACW   = SAMPLE_W + WEIGHT_BITS + 4;
    localparam int CW    = $clog2(ACW+1);

    typedef enum logic [2:0] {
        ST_IDLE, ST_TAP, ST_FLUSH, ST_DIV, ST_OUT
    } t_state;

    t_state                 r_state;
    logic [AW-1:0]          r_center;
    t_job_flags             r_flags;
    logic [1:0]             r_dx, r_dy;
    logic                   r_mac_v;
    logic [WEIGHT_BITS-1:0] r_mac_w;
    logic [ACW-1:0]         r_acc;
    logic [SW-1:0]          r_wsum;
    logic [SW:0]            r_rem;
    logic [CW-1:0]          r_cnt;
    logic                   r_err;

    logic [TW-1:0]          t_sum, roff, coff, t_red;
    logic [3:0]             k;
    logic                   tap_ok;
    logic [WEIGHT_BITS-1:0] wsel;
    logic [SW:0]            rem_sh;
    logic                   q_bit;
    logic [SAMPLE_W+WEIGHT_BITS-1:0] prod;

    always_comb begin
        roff = (r_dy == 2'd0) ? (TW'(0) - TW'(i_rowstep)) :
               (r_dy == 2'd2) ? TW'(i_rowstep) : '0;
        coff = (r_dx == 2'd0) ? (i_color ? TW'(-3) : TW'(-1)) :
               (r_dx == 2'd2) ? (i_color ? TW'(3) : TW'(1)) : '0;
        t_sum = TW'(r_center) + TW'(DEPTH) + roff + coff;
        if (t_sum >= TW'(2*DEPTH)) begin
            t_red = t_sum - TW'(2*DEPTH);
        end else if (t_sum >= TW'(DEPTH)) begin
            t_red = t_sum - TW'(DEPTH);
        end else begin
            t_red = t_sum;
        end
        o_raddr = t_red[AW-1:0];

        k = 4'(r_dx) * 4'd3 + 4'(r_dy);
        tap_ok = !((r_dx == 2'd0) && r_flags.left) && !((r_dx == 2'd2) && r_flags.right)
              && !((r_dy == 2'd0) && r_flags.top) && !((r_dy == 2'd2) && r_flags.bottom);
        wsel = tap_ok ? i_kernel[WEIGHT_BITS*k +: WEIGHT_BITS] : '0;

        prod   = r_mac_w * i_rdata;
        rem_sh = {r_rem[SW-1:0], r_acc[ACW-1]};
        q_bit  = (rem_sh >= {1'b0, r_wsum});

        o_pop  = (r_state == ST_IDLE) && !i_fifo_empty;
        o_idle = (r_state == ST_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            o_valid <= 1'b0;
            r_mac_v <= 1'b0;
        end else begin
            // In ST_OUT the output register is either held or reloaded below.
            if (o_valid && i_ready && (r_state != ST_OUT)) begin
                o_valid <= 1'b0;
            end
            if ((r_state == ST_TAP || r_state == ST_FLUSH) && r_mac_v) begin
                r_acc  <= r_acc + ACW'(prod);
                r_wsum <= r_wsum + SW'(r_mac_w);
            end
            case (r_state)
                ST_IDLE: begin
                    if (!i_fifo_empty) begin
                        r_center <= i_job_addr;
                        r_flags  <= i_job_flags;
                        r_dx     <= 2'd0;
                        r_dy     <= 2'd0;
                        r_acc    <= '0;
                        r_wsum   <= '0;
                        r_mac_v  <= 1'b0;
                        r_state  <= ST_TAP;
                    end
                end
                ST_TAP: begin
                    r_mac_w <= wsel;
                    r_mac_v <= 1'b1;
                    if (r_dy == 2'd2) begin
                        r_dy <= 2'd0;
                        if (r_dx == 2'd2) begin
                            r_state <= ST_FLUSH;
                        end else begin
                            r_dx <= r_dx + 2'd1;
                        end
                    end else begin
                        r_dy <= r_dy + 2'd1;
                    end
                end
                ST_FLUSH: begin
                    r_mac_v <= 1'b0;
                    r_rem   <= '0;
                    r_cnt   <= CW'(ACW);
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (r_wsum == '0) begin
                        r_err   <= 1'b1;
                        r_state <= ST_OUT;
                    end else begin
                        r_err <= 1'b0;
                        r_rem <= q_bit ? (rem_sh - {1'b0, r_wsum}) : rem_sh;
                        r_acc <= {r_acc[ACW-2:0], q_bit};
                        r_cnt <= r_cnt - CW'(1);
                        if (r_cnt == CW'(1)) begin
                            r_state <= ST_OUT;
                        end
                    end
                end
                ST_OUT: begin
                    if (!o_valid || i_ready) begin
                        o_valid    <= 1'b1;
                        o_value    <= r_err ? '0 : r_acc[SAMPLE_W-1:0];
                        o_zero_err <= r_err;
                        o_last     <= r_flags.last;
                        r_state    <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire
